>>> hdl/mnte_pkg.sv
// mnte_pkg: shared constants, entry layout and controller/datapath bundles
// for the note track encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mnte_pkg;

   // store geometry
   localparam int MAX_NOTES   = 256;
   localparam int STORE_DEPTH = 2 * MAX_NOTES;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // entry layout: done[51] tick[50:19] on[18] pitch[17:11] chan[10:7] vel[6:0]
   localparam int ENTRY_W = 52;
   localparam int KEY_LSB = 11;
   localparam int KEY_MSB = 50;
   localparam int TICK_W  = 32;
   localparam int PROD_W  = 47;

   localparam logic [14:0] TPB_RESET = 15'd480;

   // operation codes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_EMIT  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;

   // track bytes
   localparam logic [7:0] NOTE_ON_CODE  = 8'h90;
   localparam logic [7:0] NOTE_OFF_CODE = 8'h80;
   localparam logic [7:0] META_CODE     = 8'hFF;
   localparam logic [7:0] EOT_CODE      = 8'h2F;

   typedef struct packed {
      logic       capture;
      logic       clear;
      logic       mul_a;
      logic       mul_b;
      logic       wr_on;
      logic       wr_off;
      logic       scan_start;
      logic       scan_run;
      logic       mark;
      logic       push_byte;
      logic       push_status;
      logic [1:0] status_code;
   } mnte_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic scan_done;
      logic out_free;
      logic bytes_last;
   } mnte_stat_type;

endpackage
`default_nettype wire

>>> hdl/mnte_ctrl.sv
// mnte_ctrl: request sequencer for load, emit and clear.
// Depends on mnte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mnte_ctrl
   import mnte_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [1:0]    req_operation,
   output logic               req_stall,
   input  mnte_stat_type      stat,
   output mnte_cmd_type       cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MUL_A  = 4'd1;
   localparam logic [3:0] S_MUL_B  = 4'd2;
   localparam logic [3:0] S_WR_ON  = 4'd3;
   localparam logic [3:0] S_WR_OFF = 4'd4;
   localparam logic [3:0] S_SCAN   = 4'd5;
   localparam logic [3:0] S_MARK   = 4'd6;
   localparam logic [3:0] S_BYTES  = 4'd7;
   localparam logic [3:0] S_REPLY  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] reply_ff, reply_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      reply_in = reply_ff;
      cmd      = '0;
      cmd.status_code = reply_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_operation)
                  OP_LOAD: begin
                     if (stat.full) begin
                        reply_in = ST_FULL;
                        state_in = S_REPLY;
                     end else begin
                        state_in = S_MUL_A;
                     end
                  end
                  OP_EMIT: begin
                     if (stat.empty) begin
                        reply_in = ST_NONE;
                        state_in = S_REPLY;
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     reply_in  = ST_OK;
                     state_in  = S_REPLY;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_MUL_A:  begin cmd.mul_a = 1'b1; state_in = S_MUL_B; end
         S_MUL_B:  begin cmd.mul_b = 1'b1; state_in = S_WR_ON; end
         S_WR_ON:  begin cmd.wr_on = 1'b1; state_in = S_WR_OFF; end
         S_WR_OFF: begin
            cmd.wr_off = 1'b1;
            reply_in   = ST_OK;
            state_in   = S_REPLY;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = S_MARK;
            end
         end
         S_MARK: begin cmd.mark = 1'b1; state_in = S_BYTES; end
         S_BYTES: begin
            if (stat.out_free) begin
               cmd.push_byte = 1'b1;
               if (stat.bytes_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_REPLY: begin
            if (stat.out_free) begin
               cmd.push_status = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         reply_ff <= ST_OK;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/mnte_dp.sv
// mnte_dp: event store, tick multiplier, scan compare, byte builder and
// result register. Depends on mnte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mnte_dp
   import mnte_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  mnte_cmd_type       cmd,
   output mnte_stat_type      stat,
   input  wire logic          csr_valid,
   input  wire logic [14:0]   csr_ticks_per_beat,
   input  wire logic [31:0]   req_start_beat,
   input  wire logic [31:0]   req_duration_beats,
   input  wire logic [4:0]    req_channel,
   input  wire logic [6:0]    req_pitch,
   input  wire logic [6:0]    req_velocity,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last,
   output logic               rsp_end_marker,
   output logic [15:0]        rsp_track_bytes,
   output logic [1:0]         rsp_status
);

   logic [14:0]        tpb_ff;
   logic [31:0]        start_ff, dur_ff;
   logic [3:0]         chan_ff;
   logic [6:0]         pitch_ff, vel_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [TICK_W-1:0]  on_t_ff, end_t_ff, prev_ff;
   logic [CNT_W-1:0]   count_ff, emit_cnt_ff, idx_ff;
   logic [15:0]        byte_total_ff;
   logic [ENTRY_W-1:0] mem [STORE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff, best_idx_ff;
   logic [ENTRY_W-1:0] best_ff;
   logic               found_ff;
   logic [TICK_W-1:0]  delta_ff;
   logic [2:0]         groups_ff;
   logic               end_ff;
   logic [3:0]         sel_ff;
   logic               rsp_valid_ff, rsp_last_ff, rsp_end_ff;
   logic [7:0]         rsp_byte_ff;
   logic [15:0]        rsp_track_ff;
   logic [1:0]         rsp_status_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff <= TPB_RESET;
      end else if (csr_valid) begin
         tpb_ff <= csr_ticks_per_beat;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         start_ff <= req_start_beat;
         dur_ff   <= req_duration_beats;
         chan_ff  <= req_channel[3:0] - 4'd1;
         pitch_ff <= req_pitch;
         vel_ff   <= req_velocity;
      end
   end

   // beat to tick: clamp at zero, multiply, round, saturate
   logic signed [32:0] sum_s;
   logic [31:0]        mul_op;
   logic [47:0]        rnd;
   logic [TICK_W-1:0]  sat_t, on_inc, off_t;
   assign sum_s  = 33'(signed'(start_ff)) + 33'(signed'(dur_ff));
   always_comb begin
      if (cmd.mul_a) begin
         mul_op = (signed'(start_ff) > 0) ? start_ff : 32'd0;
      end else begin
         mul_op = (sum_s > 0) ? sum_s[31:0] : 32'd0;
      end
   end
   assign rnd    = {1'b0, prod_ff} + 48'd128;
   assign sat_t  = (rnd[47:40] != 8'd0) ? '1 : rnd[39:8];
   assign on_inc = (on_t_ff == '1) ? on_t_ff : on_t_ff + 32'd1;
   assign off_t  = (end_t_ff > on_inc) ? end_t_ff : on_inc;

   always_ff @(posedge clock) begin
      if (cmd.mul_a || cmd.mul_b) begin
         prod_ff <= PROD_W'(mul_op * tpb_ff);
      end
      if (cmd.mul_b) begin
         on_t_ff <= sat_t;
      end
      if (cmd.wr_on) begin
         end_t_ff <= sat_t;
      end
   end

   // store write port
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = '0;
      if (cmd.wr_on) begin
         wr_data = {1'b0, on_t_ff, 1'b1, pitch_ff, chan_ff, vel_ff};
      end else if (cmd.wr_off) begin
         wr_addr = count_ff[IDX_W-1:0] + IDX_W'(1);
         wr_data = {1'b0, off_t, 1'b0, pitch_ff, chan_ff, 7'd0};
      end else if (cmd.mark) begin
         wr_addr = best_idx_ff;
         wr_data = {1'b1, best_ff[ENTRY_W-2:0]};
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx_ff[IDX_W-1:0]];
   end

   // scan: one read per cycle, compared in the cycle after the read
   logic issue, better;
   assign issue  = cmd.scan_run && (idx_ff < count_ff);
   assign better = rd_vld_ff && !rd_data_ff[ENTRY_W-1] &&
                   (!found_ff || rd_data_ff[KEY_MSB:KEY_LSB] < best_ff[KEY_MSB:KEY_LSB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         idx_ff    <= '0;
      end else if (cmd.scan_start) begin
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         rd_vld_ff <= issue;
         if (issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (better) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff[IDX_W-1:0];
      if (better) begin
         best_ff     <= rd_data_ff;
         best_idx_ff <= rd_idx_ff;
      end
   end

   // delta time and VLQ group count
   logic [TICK_W-1:0] best_tick, delta;
   logic [2:0]        groups;
   assign best_tick = best_ff[50:19];
   assign delta     = best_tick - prev_ff;
   always_comb begin
      if (delta[31:28] != 4'd0)      groups = 3'd5;
      else if (delta[27:21] != 7'd0) groups = 3'd4;
      else if (delta[20:14] != 7'd0) groups = 3'd3;
      else if (delta[13:7] != 7'd0)  groups = 3'd2;
      else                           groups = 3'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.mark) begin
         delta_ff  <= delta;
         groups_ff <= groups;
         end_ff    <= (emit_cnt_ff + CNT_W'(1)) >= count_ff;
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff      <= '0;
         emit_cnt_ff   <= '0;
         prev_ff       <= '0;
         byte_total_ff <= '0;
         sel_ff        <= '0;
      end else begin
         if (cmd.wr_off) begin
            count_ff <= count_ff + CNT_W'(2);
         end
         if (cmd.mark) begin
            emit_cnt_ff <= emit_cnt_ff + CNT_W'(1);
            prev_ff     <= best_tick;
            sel_ff      <= '0;
         end
         if (cmd.push_byte) begin
            byte_total_ff <= byte_total_ff + 16'd1;
            sel_ff        <= sel_ff + 4'd1;
         end
      end
   end

   // byte builder
   logic [3:0] total, post;
   logic [2:0] grp;
   logic [7:0] cur_byte;
   logic       is_end, is_last;
   assign total   = 4'(groups_ff) + 4'd3 + (end_ff ? 4'd4 : 4'd0);
   assign is_last = (sel_ff == total - 4'd1);
   assign post    = sel_ff - 4'(groups_ff);
   assign grp     = groups_ff - 3'd1 - sel_ff[2:0];
   assign is_end  = (sel_ff >= 4'(groups_ff) + 4'd3);

   always_comb begin
      cur_byte = 8'd0;
      if (sel_ff < 4'(groups_ff)) begin
         case (grp)
            3'd0: cur_byte = {1'b0, delta_ff[6:0]};
            3'd1: cur_byte = {1'b1, delta_ff[13:7]};
            3'd2: cur_byte = {1'b1, delta_ff[20:14]};
            3'd3: cur_byte = {1'b1, delta_ff[27:21]};
            3'd4: cur_byte = {1'b1, 3'd0, delta_ff[31:28]};
            default: cur_byte = 8'd0;
         endcase
      end else begin
         case (post)
            4'd0: cur_byte = (best_ff[18] ? NOTE_ON_CODE : NOTE_OFF_CODE) |
                             {4'd0, best_ff[10:7]};
            4'd1: cur_byte = {1'b0, best_ff[17:11]};
            4'd2: cur_byte = best_ff[18] ? {1'b0, best_ff[6:0]} : 8'd0;
            4'd4: cur_byte = META_CODE;
            4'd5: cur_byte = EOT_CODE;
            default: cur_byte = 8'd0;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push_byte || cmd.push_status) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_status) begin
         rsp_byte_ff   <= 8'd0;
         rsp_last_ff   <= 1'b1;
         rsp_end_ff    <= 1'b0;
         rsp_track_ff  <= byte_total_ff;
         rsp_status_ff <= cmd.status_code;
      end else if (cmd.push_byte) begin
         rsp_byte_ff   <= cur_byte;
         rsp_last_ff   <= is_last;
         rsp_end_ff    <= is_end;
         rsp_track_ff  <= byte_total_ff + 16'd1;
         rsp_status_ff <= ST_OK;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_end_marker  = rsp_end_ff;
   assign rsp_track_bytes = rsp_track_ff;
   assign rsp_status      = rsp_status_ff;

   // status to controller
   assign stat.full       = count_ff > CNT_W'(STORE_DEPTH - 2);
   assign stat.empty      = (emit_cnt_ff == count_ff);
   assign stat.scan_done  = (idx_ff >= count_ff) && !rd_vld_ff;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.bytes_last = is_last;

`ifndef SYNTH
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff <= count_ff)
      else $error("emitted count above event count");
   a_mark_found: assert property (@(posedge clock) disable iff (reset)
      cmd.mark |-> found_ff)
      else $error("event marked without a scan hit");
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_last_ff)
      else $error("error status not on final result");
   a_even_count: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_off |=> !count_ff[0])
      else $error("odd event count after load");
`endif

endmodule
`default_nettype wire

>>> hdl/midi_note_track_encoder.sv
// midi_note_track_encoder: top level joining controller and datapath.
// Depends on mnte_pkg, mnte_ctrl, mnte_dp.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | operation, note fields
//   rsp     | out       | rsp_valid/rsp_stall | byte, last, end, count, status
//   csr     | in        | csr_valid/csr_ready | ticks_per_beat
//
// Load: two passes through one 32x15 multiplier, then two store writes.
// Emit: a store scan over all events (one read port), then the track bytes
//   (4 to 12), one per cycle as the result side accepts them.
// Clear and status-only requests go straight from idle to the reply state. Reset is synchronous; no clear pass.
// A stalled result register holds; the next request waits in req_stall.
`timescale 1ns / 1ps
`default_nettype none
module midi_note_track_encoder
   import mnte_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_operation,
   input  wire logic [31:0]   req_start_beat,
   input  wire logic [31:0]   req_duration_beats,
   input  wire logic [4:0]    req_channel,
   input  wire logic [6:0]    req_pitch,
   input  wire logic [6:0]    req_velocity,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last,
   output logic               rsp_end_marker,
   output logic [15:0]        rsp_track_bytes,
   output logic [1:0]         rsp_status,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [14:0]   csr_ticks_per_beat
);

   mnte_cmd_type  cmd;
   mnte_stat_type stat;

   assign csr_ready = 1'b1;

   mnte_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   mnte_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_valid          (csr_valid),
      .csr_ticks_per_beat (csr_ticks_per_beat),
      .req_start_beat     (req_start_beat),
      .req_duration_beats (req_duration_beats),
      .req_channel        (req_channel),
      .req_pitch          (req_pitch),
      .req_velocity       (req_velocity),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last),
      .rsp_end_marker     (rsp_end_marker),
      .rsp_track_bytes    (rsp_track_bytes),
      .rsp_status         (rsp_status)
   );

endmodule
`default_nettype wire
